[rtl/htdd_pkg.sv]
// Package of the Huffman tree delta decoder: table depth, transaction payload types,
// command, status and result kind codes, and configuration register indexes.
// Depends on nothing.
package htdd_pkg;

    localparam int TABLE_DEPTH = 512;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_WORD  = 2'd2,
        CMD_END   = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_DELTA_MODE        = 2'd0;
    localparam logic [1:0] REG_TOTAL_SAMPLES     = 2'd1;
    localparam logic [1:0] REG_EXPECTED_CHECKSUM = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_REMAINING = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        cmd_t               command;
        logic [8:0]         entry_index;
        logic signed [15:0] left_child;
        logic signed [15:0] right_child;
        logic [7:0]         first_byte;
        logic [31:0]        code_word;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] sample;
        logic       last;
        logic [1:0] status;
    } out_item_t;

endpackage

[rtl/huffman_tree_delta_decoder.sv]
// Top level of the Huffman tree delta decoder: child-pair table memory,
// tree walk sequencer, checksum and sample counters, configuration registers.
// Depends on htdd_pkg.
//
//   Channel   Direction  Handshake              Payload
//   s_        in         s_valid / s_ready      s_data (in_item_t)
//   m_        out        m_valid / m_ready      m_data (out_item_t)
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A code word holds the input off while it is decoded: a read of the current node,
// a table read per code bit while samples remain, and the release of the final
// result. Loads hold it off while the entry is written, nonempty start items and end
// items until their result is released; ignored words and empty start items do not.
// Reset is synchronous and active low; the table itself is not cleared. A full output
// register stalls the walk at the next leaf, and the final result, until it drains.
module huffman_tree_delta_decoder
    import htdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = 9 + 2 * AW;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_FIRST = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic        delta_mode_reg;
    logic [31:0] total_samples_reg;
    logic [31:0] expected_checksum_reg;
    in_item_t    item_reg, item_next;
    logic [AW-1:0] np_reg, np_next;
    logic [7:0]  prev_reg, prev_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] csum_reg, csum_next;
    logic [4:0]  bit_reg, bit_next;
    logic        held_valid_reg, held_valid_next;
    out_item_t   held_reg, held_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;
    logic [EW-1:0] root_reg, root_next;
    logic [EW-1:0] rdata_reg;

    logic [EW-1:0] tbl_mem [TABLE_DEPTH];
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata;

    logic          slot_free, push;
    out_item_t     push_item;
    logic [4:0]    bit_dn;
    logic          word_bit, next_bit, leaf;
    logic [AW-1:0] child;
    logic [EW-1:0] step_ent;
    logic [7:0]    leaf_val, new_sample;
    logic [1:0]    end_status;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign slot_free  = !m_valid_reg || m_ready;
    assign bit_dn     = bit_reg - 5'd1;
    assign word_bit   = item_reg.code_word[bit_reg];
    assign next_bit   = item_reg.code_word[bit_dn];
    assign leaf       = rdata_reg[EW-1];
    assign leaf_val   = rdata_reg[EW-2:EW-9];
    assign new_sample = delta_mode_reg ? (prev_reg + leaf_val) : leaf_val;
    assign end_status = (left_reg != 32'd0) ? STATUS_REMAINING :
                        (csum_reg != expected_checksum_reg) ? STATUS_MISMATCH : STATUS_OK;

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        np_next         = np_reg;
        prev_next       = prev_reg;
        left_next       = left_reg;
        csum_next       = csum_reg;
        bit_next        = bit_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        root_next       = root_reg;
        mem_we          = 1'b0;
        mem_waddr       = item_reg.entry_index[AW-1:0];
        mem_wdata       = {item_reg.left_child[15], item_reg.right_child[7:0],
                           item_reg.left_child[AW-1:0], item_reg.right_child[AW-1:0]};
        mem_re          = 1'b0;
        mem_raddr       = np_reg;
        push            = 1'b0;
        push_item       = held_reg;
        step_ent        = rdata_reg;
        child           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    unique case (s_data.command)
                        CMD_LOAD: begin
                            if (32'(s_data.entry_index) < TABLE_DEPTH) begin
                                state_next = ST_LOAD;
                            end
                        end
                        CMD_START: begin
                            left_next = total_samples_reg;
                            csum_next = 32'd0;
                            np_next   = '0;
                            if (total_samples_reg != 32'd0) begin
                                prev_next       = s_data.first_byte;
                                left_next       = total_samples_reg - 32'd1;
                                held_next       = '{KIND_SAMPLE, s_data.first_byte, 1'b0,
                                                    STATUS_OK};
                                held_valid_next = 1'b1;
                                state_next      = ST_FLUSH;
                            end
                        end
                        CMD_WORD: begin
                            if (left_reg != 32'd0) begin
                                csum_next  = csum_reg + s_data.code_word;
                                mem_re     = 1'b1;
                                mem_raddr  = np_reg;
                                bit_next   = 5'd31;
                                state_next = ST_FIRST;
                            end
                        end
                        CMD_END: begin
                            held_next       = '{KIND_STATUS, 8'd0, 1'b0, end_status};
                            held_valid_next = 1'b1;
                            state_next      = ST_FLUSH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                mem_we = 1'b1;
                if (item_reg.entry_index[AW-1:0] == '0) begin
                    root_next = mem_wdata;
                end
                state_next = ST_IDLE;
            end
            ST_FIRST: begin
                child      = word_bit ? rdata_reg[AW-1:0] : rdata_reg[2*AW-1:AW];
                mem_re     = 1'b1;
                mem_raddr  = child;
                np_next    = child;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (leaf) begin
                    if (!held_valid_reg || slot_free) begin
                        push            = held_valid_reg;
                        push_item       = held_reg;
                        prev_next       = new_sample;
                        held_next       = '{KIND_SAMPLE, new_sample, 1'b0, STATUS_OK};
                        held_valid_next = 1'b1;
                        left_next       = left_reg - 32'd1;
                        np_next         = '0;
                        if (bit_reg == 5'd0 || left_reg == 32'd1) begin
                            state_next = ST_FLUSH;
                        end else begin
                            step_ent  = root_reg;
                            child     = next_bit ? step_ent[AW-1:0] : step_ent[2*AW-1:AW];
                            mem_re    = 1'b1;
                            mem_raddr = child;
                            np_next   = child;
                            bit_next  = bit_dn;
                        end
                    end
                end else if (bit_reg == 5'd0) begin
                    state_next = ST_FLUSH;
                end else begin
                    child     = next_bit ? step_ent[AW-1:0] : step_ent[2*AW-1:AW];
                    mem_re    = 1'b1;
                    mem_raddr = child;
                    np_next   = child;
                    bit_next  = bit_dn;
                end
            end
            ST_FLUSH: begin
                if (!held_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    push            = 1'b1;
                    push_item       = held_reg;
                    push_item.last  = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (push) begin
            m_valid_next = 1'b1;
            m_data_next  = push_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= tbl_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        bit_reg    <= bit_next;
        held_reg   <= held_next;
        m_data_reg <= m_data_next;
        root_reg   <= root_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= ST_IDLE;
            np_reg                <= '0;
            prev_reg              <= 8'd0;
            left_reg              <= 32'd0;
            csum_reg              <= 32'd0;
            held_valid_reg        <= 1'b0;
            m_valid_reg           <= 1'b0;
            delta_mode_reg        <= 1'b1;
            total_samples_reg     <= 32'd0;
            expected_checksum_reg <= 32'd0;
        end else begin
            state_reg      <= state_next;
            np_reg         <= np_next;
            prev_reg       <= prev_next;
            left_reg       <= left_next;
            csum_reg       <= csum_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_DELTA_MODE:        delta_mode_reg        <= cfg_data[0];
                    REG_TOTAL_SAMPLES:     total_samples_reg     <= cfg_data;
                    REG_EXPECTED_CHECKSUM: expected_checksum_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

[rtl/htdd_checker.sv]
// Port-level checker of the Huffman tree delta decoder, bound to the top level.
// Depends on htdd_pkg and on huffman_tree_delta_decoder.
module htdd_checker
    import htdd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_reset_clears_valid: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid was not cleared by reset.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result transaction changed or vanished.");

    a_status_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_STATUS |-> m_data.last && m_data.sample == 8'd0
            && m_data.status != 2'd3)
        else $error("Status transaction is not a lone final result.");

    a_sample_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_SAMPLE |-> m_data.status == STATUS_OK)
        else $error("Sample transaction carries a nonzero status.");

endmodule

bind huffman_tree_delta_decoder htdd_checker u_htdd_checker (.*);
